// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define AGX_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);

// Clocked assertion that is also checked during reset.
`define AGX_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

// File: rtl/agxc_pkg.sv
// ----------------------------------------------------------------------------
// agxc_pkg
// Types, constants and saturating helpers of the affine-gap X-drop column.
// ----------------------------------------------------------------------------
`default_nettype none

package agxc_pkg;

	localparam int SCORE_W     = 32;
	localparam int SUM_W       = SCORE_W + 1;
	localparam int GAP_W       = 9;
	localparam int ROOM_W      = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_EXTRA_DEF = 63;

	// minus-infinity floor and top of the score range
	localparam logic signed [SCORE_W-1:0] NINF = 32'sh8000_0064;
	localparam logic signed [SCORE_W-1:0] SMAX = 32'sh7FFF_FFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_PEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT_PEN  = 2'd1;

	localparam logic signed [GAP_W-1:0] OPEN_PEN_RST = -9'sd5;
	localparam logic signed [GAP_W-1:0] EXT_PEN_RST  = -9'sd2;

	// front queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [SCORE_W-1:0] prev_score;
		logic signed [SCORE_W-1:0] prev_del;
		logic signed [SCORE_W-1:0] profile_score;
		logic signed [SCORE_W-1:0] cutoff;
		logic                      first_cell;
		logic                      diag_only;
		logic                      last_cell;
		logic [ROOM_W-1:0]         room;
	} cell_item_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic signed [SCORE_W-1:0] ins_val;
		logic signed [SCORE_W-1:0] del_val;
		logic                      column_end;
	} result_item_t;

	// classified queue entry handed from front to back
	typedef struct packed {
		logic signed [SCORE_W-1:0] prev_score;
		logic signed [SCORE_W-1:0] prev_del;
		logic signed [SCORE_W-1:0] profile_score;
		logic signed [SCORE_W-1:0] cutoff;
		logic                      first;
		logic                      tail;
		logic                      last;
		logic [ROOM_W-1:0]         limit;
	} cell_entry_t;

	typedef struct packed {
		logic signed [GAP_W-1:0] open_pen;
		logic signed [GAP_W-1:0] ext_pen;
	} gap_cfg_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SAT,
		B_PICK,
		B_XSUM,
		B_XPICK
	} back_state_t;

	// score plus score, one guard bit
	function automatic logic signed [SUM_W-1:0] add_score(
		input logic signed [SCORE_W-1:0] a,
		input logic signed [SCORE_W-1:0] b
	);
		add_score = $signed({a[SCORE_W-1], a}) + $signed({b[SCORE_W-1], b});
	endfunction

	// score plus gap penalty, one guard bit
	function automatic logic signed [SUM_W-1:0] add_gap(
		input logic signed [SCORE_W-1:0] a,
		input logic signed [GAP_W-1:0]   g
	);
		add_gap = $signed({a[SCORE_W-1], a}) +
			$signed({{(SUM_W-GAP_W){g[GAP_W-1]}}, g});
	endfunction

	function automatic logic signed [SUM_W-1:0] max_sum(
		input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b
	);
		max_sum = (a > b) ? a : b;
	endfunction

	function automatic logic signed [SCORE_W-1:0] max_score(
		input logic signed [SCORE_W-1:0] a,
		input logic signed [SCORE_W-1:0] b
	);
		max_score = (a > b) ? a : b;
	endfunction

	// clamp into [NINF, SMAX]
	function automatic logic signed [SCORE_W-1:0] sat(
		input logic signed [SUM_W-1:0] x
	);
		logic signed [SUM_W-1:0] lo;
		logic signed [SUM_W-1:0] hi;
		lo = $signed({NINF[SCORE_W-1], NINF});
		hi = $signed({SMAX[SCORE_W-1], SMAX});
		if (x < lo) begin
			sat = NINF;
		end else if (x > hi) begin
			sat = SMAX;
		end else begin
			sat = x[SCORE_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/agxc_front.sv
// ----------------------------------------------------------------------------
// agxc_front
// Accepts cell items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module agxc_front #(
	parameter int MAX_EXTRA = agxc_pkg::MAX_EXTRA_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cell_valid,
	output logic                   cell_ready,
	input  agxc_pkg::cell_item_t   cell_item,
	output logic                   head_valid,
	output agxc_pkg::cell_entry_t  head,
	input  wire                    pop
);

	localparam logic [agxc_pkg::ROOM_W-1:0] MAX_EXTRA_L = agxc_pkg::ROOM_W'(MAX_EXTRA);
	localparam logic [agxc_pkg::QPTR_W-1:0] PTR_LAST =
		agxc_pkg::QPTR_W'(agxc_pkg::QUEUE_DEPTH - 1);
	localparam logic [agxc_pkg::QCNT_W-1:0] CNT_FULL =
		agxc_pkg::QCNT_W'(agxc_pkg::QUEUE_DEPTH);

	agxc_pkg::cell_entry_t             entry_q [agxc_pkg::QUEUE_DEPTH];
	agxc_pkg::cell_entry_t             cls;
	logic [agxc_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [agxc_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [agxc_pkg::QCNT_W-1:0]       count_q;
	logic                              push;
	logic                              do_pop;

	// classify: map flags and cap the tail room
	always_comb begin
		cls.prev_score    = cell_item.prev_score;
		cls.prev_del      = cell_item.prev_del;
		cls.profile_score = cell_item.profile_score;
		cls.cutoff        = cell_item.cutoff;
		cls.first         = cell_item.first_cell;
		cls.tail          = cell_item.diag_only;
		cls.last          = cell_item.last_cell;
		cls.limit         = (cell_item.room < MAX_EXTRA_L) ? cell_item.room : MAX_EXTRA_L;
	end

	assign cell_ready = (count_q != CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign push       = cell_valid && cell_ready;
	assign do_pop     = pop && head_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/agxc_back.sv
// ----------------------------------------------------------------------------
// agxc_back
// Cell sequencer: scores one queued cell, appends insertion cells at column
// end, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module agxc_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  agxc_pkg::gap_cfg_t      cfg,
	input  wire                     head_valid,
	input  agxc_pkg::cell_entry_t   head,
	output logic                    pop,
	output logic                    result_valid,
	input  wire                     result_ready,
	output agxc_pkg::result_item_t  result_item
);

	agxc_pkg::back_state_t state_q, state_d;

	// chain state
	logic signed [agxc_pkg::SCORE_W-1:0] diag_q, above_q, above_ins_q;
	agxc_pkg::cell_entry_t               item_q;
	logic [agxc_pkg::ROOM_W-1:0]         cnt_q;
	agxc_pkg::result_item_t              pend_q;

	// raw sums
	logic signed [agxc_pkg::SUM_W-1:0] m_sum_s1, do_sum_s1, de_sum_s1;
	logic signed [agxc_pkg::SUM_W-1:0] io_sum_s1, ie_sum_s1;
	// saturated and pruned candidates
	logic signed [agxc_pkg::SCORE_W-1:0] match_s2, del_s2, ins_s2;
	logic                                ins_ok_s2;

	// result register
	logic                   res_valid_q;
	agxc_pkg::result_item_t res_q;
	logic                   out_free;

	// control strobes
	logic ld_sums, ld_ins_sums, ld_sat, pick_emit, pick_pend, x_emit, x_more;

	// combinational datapath
	logic signed [agxc_pkg::SCORE_W-1:0] match_c, del_raw_c, del_c, ins_c;
	logic signed [agxc_pkg::SCORE_W-1:0] body_c, s0_c, pick_s, pick_e;
	logic signed [agxc_pkg::SCORE_W-1:0] x_ins;

	assign out_free = !res_valid_q || result_ready;

	// second stage: saturate and prune
	always_comb begin
		match_c   = item_q.first ? agxc_pkg::NINF : agxc_pkg::sat(m_sum_s1);
		del_raw_c = agxc_pkg::sat(agxc_pkg::max_sum(do_sum_s1, de_sum_s1));
		del_c     = (item_q.tail || (del_raw_c < item_q.cutoff)) ? agxc_pkg::NINF
			: del_raw_c;
		ins_c     = agxc_pkg::sat(agxc_pkg::max_sum(io_sum_s1, ie_sum_s1));
	end

	// third stage: pick the cell score
	always_comb begin
		body_c = agxc_pkg::max_score(del_s2, match_s2);
		if (item_q.tail) begin
			s0_c = (match_s2 >= item_q.cutoff) ? match_s2 : agxc_pkg::NINF;
		end else begin
			s0_c = (body_c < item_q.cutoff) ? agxc_pkg::NINF : body_c;
		end
		pick_e = ins_ok_s2 ? ins_s2 : agxc_pkg::NINF;
		pick_s = ins_ok_s2 ? agxc_pkg::max_score(s0_c, ins_s2) : s0_c;
	end

	// appended insertion cell
	assign x_ins  = agxc_pkg::sat(agxc_pkg::max_sum(io_sum_s1, ie_sum_s1));
	assign x_more = (cnt_q < item_q.limit) && (above_q >= item_q.cutoff) &&
		(x_ins >= item_q.cutoff);

	// next state and strobes
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		ld_sums     = 1'b0;
		ld_ins_sums = 1'b0;
		ld_sat      = 1'b0;
		pick_emit   = 1'b0;
		pick_pend   = 1'b0;
		x_emit      = 1'b0;
		case (state_q)
			agxc_pkg::B_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					ld_sums = 1'b1;
					state_d = agxc_pkg::B_SAT;
				end
			end
			agxc_pkg::B_SAT: begin
				ld_sat  = 1'b1;
				state_d = agxc_pkg::B_PICK;
			end
			agxc_pkg::B_PICK: begin
				if (item_q.last) begin
					pick_pend = 1'b1;
					state_d   = agxc_pkg::B_XSUM;
				end else if (out_free) begin
					pick_emit = 1'b1;
					state_d   = agxc_pkg::B_IDLE;
				end
			end
			agxc_pkg::B_XSUM: begin
				ld_ins_sums = 1'b1;
				state_d     = agxc_pkg::B_XPICK;
			end
			agxc_pkg::B_XPICK: begin
				if (out_free) begin
					x_emit  = 1'b1;
					state_d = x_more ? agxc_pkg::B_XSUM : agxc_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = agxc_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= agxc_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working item and arithmetic stages
	always_ff @(posedge clk) begin
		if (ld_sums) begin
			item_q    <= head;
			m_sum_s1  <= agxc_pkg::add_score(diag_q, head.profile_score);
			do_sum_s1 <= agxc_pkg::add_gap(head.prev_score, cfg.open_pen);
			de_sum_s1 <= agxc_pkg::add_gap(head.prev_del, cfg.ext_pen);
		end
		if (ld_sums || ld_ins_sums) begin
			io_sum_s1 <= agxc_pkg::add_gap(above_q, cfg.open_pen);
			ie_sum_s1 <= agxc_pkg::add_gap(above_ins_q, cfg.ext_pen);
		end
		if (ld_sat) begin
			match_s2  <= match_c;
			del_s2    <= del_c;
			ins_s2    <= ins_c;
			ins_ok_s2 <= !item_q.first && (ins_c >= item_q.cutoff);
		end
		// held result of the last cell until its successor is known
		if (pick_pend) begin
			pend_q <= '{score: pick_s, ins_val: pick_e, del_val: del_s2,
				column_end: 1'b0};
		end else if (x_emit && x_more) begin
			pend_q <= '{score: x_ins, ins_val: x_ins, del_val: agxc_pkg::NINF,
				column_end: 1'b0};
		end
	end

	// chain state and appended-cell count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diag_q      <= agxc_pkg::NINF;
			above_q     <= agxc_pkg::NINF;
			above_ins_q <= agxc_pkg::NINF;
			cnt_q       <= '0;
		end else begin
			if (pick_emit || pick_pend) begin
				above_q     <= pick_s;
				above_ins_q <= pick_e;
				if (!item_q.tail) begin
					diag_q <= item_q.prev_score;
				end
				cnt_q <= '0;
			end else if (x_emit) begin
				if (x_more) begin
					above_q     <= x_ins;
					above_ins_q <= x_ins;
					cnt_q       <= cnt_q + 1'b1;
				end else begin
					// column done: chain restarts
					diag_q      <= agxc_pkg::NINF;
					above_q     <= agxc_pkg::NINF;
					above_ins_q <= agxc_pkg::NINF;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pick_emit || x_emit) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pick_emit) begin
			res_q <= '{score: pick_s, ins_val: pick_e, del_val: del_s2,
				column_end: 1'b0};
		end else if (x_emit) begin
			res_q <= '{score: pend_q.score, ins_val: pend_q.ins_val,
				del_val: pend_q.del_val, column_end: !x_more};
		end
	end

	assign result_valid = res_valid_q;
	assign result_item  = res_q;

endmodule

`default_nettype wire

// File: rtl/affine_gap_xdrop_column.sv
// ----------------------------------------------------------------------------
// affine_gap_xdrop_column
// Affine-gap alignment column engine with X-drop pruning, one cell per item.
// ----------------------------------------------------------------------------
// Usage:
//   cell_valid/cell_ready/cell_item carries one table cell per item; the
//   result channel result_valid/result_ready/result_item returns one item per
//   cell, plus appended insertion cells after a cell marked last_cell. The
//   final result of a column carries column_end.
//   cfg_valid/cfg_ready/cfg_index/cfg_data writes the gap open penalty
//   (index 0) and the gap extend penalty (index 1); cfg_ready is always
//   high. Write only when idle.
// Timing:
//   An ordinary cell is popped and goes through the sum, saturate and pick
//   states before its result is registered. The scoring sequencer ends one
//   cell before it takes the next, as the insertion chain feeds each cell from
//   the one above it. A last cell adds an XSUM/XPICK pass per appended cell
//   and one for the final check. A 2-entry queue takes new items meanwhile.
// Reset:
//   arst_n clears the queue, the result register and the chain state, and
//   loads open penalty = -5, extend penalty = -2.
// Stall:
//   A result holds in the output register while result_ready is low; the
//   sequencer waits and the queue fills, then cell_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_gap_xdrop_column #(
	parameter int MAX_EXTRA = agxc_pkg::MAX_EXTRA_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cell_valid,
	output logic                               cell_ready,
	input  agxc_pkg::cell_item_t               cell_item,
	output logic                               result_valid,
	input  wire                                result_ready,
	output agxc_pkg::result_item_t             result_item,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [agxc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [agxc_pkg::GAP_W-1:0]          cfg_data
);

	agxc_pkg::gap_cfg_t    cfg_q;
	agxc_pkg::cell_entry_t head;
	logic                  head_valid;
	logic                  pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_pen <= agxc_pkg::OPEN_PEN_RST;
			cfg_q.ext_pen  <= agxc_pkg::EXT_PEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				agxc_pkg::CFG_OPEN_PEN: begin
					cfg_q.open_pen <= $signed(cfg_data);
				end
				agxc_pkg::CFG_EXT_PEN: begin
					cfg_q.ext_pen <= $signed(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	agxc_front #(
		.MAX_EXTRA (MAX_EXTRA)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_item  (cell_item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	agxc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule

`default_nettype wire

// File: rtl/agxc_checker.sv
// ----------------------------------------------------------------------------
// agxc_checker
// Port-level checks of the column engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module agxc_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           result_valid,
	input wire                           result_ready,
	input agxc_pkg::result_item_t        result_item
);

	logic res_stall;
	logic ge_ins;
	logic ge_del;

	assign res_stall = result_valid && !result_ready;
	assign ge_ins    = $signed(result_item.score) >= $signed(result_item.ins_val);
	assign ge_del    = $signed(result_item.score) >= $signed(result_item.del_val);

	// a stalled result item stays offered
	`AGX_ASSERT(a_valid_hold, clk, arst_n, res_stall |=> result_valid, "held valid dropped")

	// a stalled result item holds its payload
	`AGX_ASSERT(a_item_hold, clk, arst_n, res_stall |=> $stable(result_item), "held item changed")

	// best score dominates the insertion score
	`AGX_ASSERT(a_score_ge_ins, clk, arst_n, result_valid |-> ge_ins, "score below insertion")

	// best score dominates the deletion score
	`AGX_ASSERT(a_score_ge_del, clk, arst_n, result_valid |-> ge_del, "score below deletion")

	// reset clears the result channel
	`AGX_ASSERT_NR(a_rst_quiet, clk, !arst_n |=> !result_valid, "result valid during reset")

endmodule

bind affine_gap_xdrop_column agxc_checker u_agxc_checker (.*);

`default_nettype wire
